### hdl/nspf_pkg.sv
// Shared types and constants for the nearest set pixel finder.
package nspf_pkg;

    localparam int COORD_BITS    = 12;
    localparam int DIST_BITS     = 2 * COORD_BITS + 1;
    localparam int SQ_BITS       = 2 * COORD_BITS;
    localparam int CFG_IDX_BITS  = 8;
    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_COL = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_ROW = CFG_IDX_BITS'(1);

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [DIST_BITS-1:0]  t_dist;

    typedef struct packed {
        t_coord pixel_col;
        t_coord pixel_row;
        logic   pixel_set;
        logic   frame_end;
    } t_pix_in;

    typedef struct packed {
        t_coord nearest_col;
        t_coord nearest_row;
        logic   detected;
        t_dist  nearest_dist_sq;
    } t_pix_out;

    // Queue entry between front and back
    typedef struct packed {
        t_coord cand_col;
        t_coord cand_row;
        logic   cand_set;
        logic   cand_end;
        t_dist  cand_dist;
    } t_cand;

    // Queue status seen by the two sides
    typedef struct packed {
        logic                     empty;
        logic [FIFO_CNT_BITS-1:0] count;
    } t_fifo_status;

endpackage

### hdl/nspf_fifo.sv
// Short candidate queue between the distance front and the search back.
module nspf_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  nspf_pkg::t_cand     i_wr_data,
    input  logic                i_pop,
    output nspf_pkg::t_cand     o_rd_data,
    output nspf_pkg::t_fifo_status o_status
);
    import nspf_pkg::*;

    t_cand                    r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr_ptr;
    logic [FIFO_PTR_BITS-1:0] r_rd_ptr;
    logic [FIFO_CNT_BITS-1:0] r_count;
    logic [FIFO_CNT_BITS-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + FIFO_CNT_BITS'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - FIFO_CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    assign o_rd_data    = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.count = r_count;

endmodule

### hdl/nspf_front.sv
// Front end: pixel accept, target registers, squared distance pipeline.
module nspf_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  nspf_pkg::t_pix_in              i_pix,
    output logic                           o_stall,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [nspf_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  nspf_pkg::t_coord               i_cfg_data,
    input  nspf_pkg::t_fifo_status         i_fifo_status,
    output logic                           o_push,
    output nspf_pkg::t_cand                o_cand
);
    import nspf_pkg::*;

    t_coord  r_target_col;
    t_coord  r_target_row;

    logic    r_s1_valid;
    t_pix_in r_s1_pix;
    t_coord  r_s1_dc;
    t_coord  r_s1_dr;

    logic    r_s2_valid;
    t_pix_in r_s2_pix;
    logic [SQ_BITS-1:0] r_s2_dc_sq;
    logic [SQ_BITS-1:0] r_s2_dr_sq;

    logic    w_accept;
    t_coord  w_dc;
    t_coord  w_dr;
    logic [FIFO_CNT_BITS-1:0] w_held;

    // queue entries plus words still in the pipe; each accepted set pixel or frame end reserves a slot
    assign w_held   = i_fifo_status.count + FIFO_CNT_BITS'(r_s1_valid)
                    + FIFO_CNT_BITS'(r_s2_valid);
    assign o_stall  = (w_held >= FIFO_CNT_BITS'(FIFO_DEPTH));
    assign w_accept = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;

    assign w_dc = (i_pix.pixel_col >= r_target_col) ? i_pix.pixel_col - r_target_col
                                                    : r_target_col - i_pix.pixel_col;
    assign w_dr = (i_pix.pixel_row >= r_target_row) ? i_pix.pixel_row - r_target_row
                                                    : r_target_row - i_pix.pixel_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_col <= '0;
            r_target_row <= '0;
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TARGET_COL: r_target_col <= i_cfg_data;
                    CFG_TARGET_ROW: r_target_row <= i_cfg_data;
                    default: ;
                endcase
            end
            // clear, unset pixels carry nothing for the back end
            r_s1_valid <= w_accept && (i_pix.pixel_set || i_pix.frame_end);
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_pix   <= i_pix;
        r_s1_dc    <= w_dc;
        r_s1_dr    <= w_dr;
        r_s2_pix   <= r_s1_pix;
        r_s2_dc_sq <= SQ_BITS'(r_s1_dc) * SQ_BITS'(r_s1_dc);
        r_s2_dr_sq <= SQ_BITS'(r_s1_dr) * SQ_BITS'(r_s1_dr);
    end

    assign o_push           = r_s2_valid;
    assign o_cand.cand_col  = r_s2_pix.pixel_col;
    assign o_cand.cand_row  = r_s2_pix.pixel_row;
    assign o_cand.cand_set  = r_s2_pix.pixel_set;
    assign o_cand.cand_end  = r_s2_pix.frame_end;
    assign o_cand.cand_dist = DIST_BITS'(r_s2_dc_sq) + DIST_BITS'(r_s2_dr_sq);

endmodule

### hdl/nspf_back.sv
// Back end: running nearest search and result register.
module nspf_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  nspf_pkg::t_fifo_status i_fifo_status,
    input  nspf_pkg::t_cand        i_cand,
    output logic                   o_pop,
    output logic                   o_valid,
    output nspf_pkg::t_pix_out     o_res,
    input  logic                   i_stall
);
    import nspf_pkg::*;

    t_coord   r_best_col;
    t_coord   r_best_row;
    t_dist    r_best_dist;
    logic     r_found;
    logic     r_out_valid;
    t_pix_out r_res;

    logic     w_take;
    t_coord   w_col;
    t_coord   w_row;
    t_dist    w_dist;
    logic     w_found;

    // a frame end waits only for the result register to free up
    assign o_pop = !i_fifo_status.empty
                && (!i_cand.cand_end || !r_out_valid || !i_stall);

    // later pixel wins a tie
    assign w_take  = i_cand.cand_set && (!r_found || (i_cand.cand_dist <= r_best_dist));
    assign w_col   = w_take ? i_cand.cand_col  : r_best_col;
    assign w_row   = w_take ? i_cand.cand_row  : r_best_row;
    assign w_dist  = w_take ? i_cand.cand_dist : r_best_dist;
    assign w_found = r_found || w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_col  <= '0;
            r_best_row  <= '0;
            r_best_dist <= '1;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (o_pop && i_cand.cand_end) || (r_out_valid && i_stall);
            if (o_pop) begin
                if (i_cand.cand_end) begin
                    r_best_col  <= '0;
                    r_best_row  <= '0;
                    r_best_dist <= '1;
                    r_found     <= 1'b0;
                end else begin
                    r_best_col  <= w_col;
                    r_best_row  <= w_row;
                    r_best_dist <= w_dist;
                    r_found     <= w_found;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cand.cand_end) begin
            r_res.nearest_col     <= w_found ? w_col  : '0;
            r_res.nearest_row     <= w_found ? w_row  : '0;
            r_res.detected        <= w_found;
            r_res.nearest_dist_sq <= w_found ? w_dist : '0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_res;

endmodule

### hdl/nearest_set_pixel_finder_top.sv
// Top level of the nearest set pixel finder.
// Usage:
//   Pixel channel (i_valid, i_pix, o_stall): one mask pixel per word in raster
//   order with its column, row, set bit and frame end mark. One pixel per clock
//   is taken while the internal queue has room.
//   Result channel (o_valid, o_res, i_stall): one word per frame, issued for the
//   pixel marked frame end: nearest set pixel, detected flag and squared
//   distance to the target; all zero with detected low for an empty frame.
//   Config channel (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data): index 0
//   writes the target column, index 1 the target row, other indexes are ignored.
//   Write only while no frame is in flight. o_cfg_ready is always high.
//   With no backpressure the frame end pixel, once accepted, passes the abs
//   diff stage, the square stage, the queue write and the compare/update into
//   the result register, and then o_valid rises.
//   While i_stall is high the result holds; pixels keep flowing until the
//   8-entry queue plus pipe is full, after which o_stall rises.
//   Reset clears the targets, the search state and all valid flags.
module nearest_set_pixel_finder_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  nspf_pkg::t_pix_in              i_pix,
    output logic                           o_stall,
    output logic                           o_valid,
    output nspf_pkg::t_pix_out             o_res,
    input  logic                           i_stall,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [nspf_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  nspf_pkg::t_coord               i_cfg_data
);
    import nspf_pkg::*;

    logic         w_push;
    logic         w_pop;
    t_cand        w_wr_cand;
    t_cand        w_rd_cand;
    t_fifo_status w_fifo_status;

    nspf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_pix         (i_pix),
        .o_stall       (o_stall),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_fifo_status (w_fifo_status),
        .o_push        (w_push),
        .o_cand        (w_wr_cand)
    );

    nspf_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_wr_data (w_wr_cand),
        .i_pop     (w_pop),
        .o_rd_data (w_rd_cand),
        .o_status  (w_fifo_status)
    );

    nspf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fifo_status (w_fifo_status),
        .i_cand        (w_rd_cand),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .o_res         (o_res),
        .i_stall       (i_stall)
    );

endmodule
